FILE: hdl/indexed_array_list_macros.svh
// Assertion macros used by the indexed array list top level.
`ifndef INDEXED_ARRAY_LIST_MACROS_SVH
`define INDEXED_ARRAY_LIST_MACROS_SVH

// Implication checked in the next cycle, sampled on clk and disabled in reset.
`define IAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked in the same cycle, sampled on clk and disabled in reset.
`define IAL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ial_pkg.sv
// Package with the types, sizes and codes of the indexed array list.
package ial_pkg;

	localparam int CAPACITY = 128;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_POS = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MOVE,
		S_DRAIN,
		S_PUT,
		S_READ,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic capture;
		logic init_ptr;
		logic step;
		logic put;
		logic read_pos;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic ok;
		op_t  op;
		logic at_edge;
		logic last;
		logic slot_free;
	} stat_t;

endpackage

FILE: hdl/ial_ctrl.sv
// Controller state machine that sequences accept, shift, write, read and reply.
module ial_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ial_pkg::stat_t stat,
	output ial_pkg::cmd_t  cmd
);
	import ial_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.ok || stat.op == OP_NONE) begin
					state_d = S_REPLY;
				end else if (stat.op == OP_INSERT) begin
					state_d = stat.at_edge ? S_PUT : S_MOVE;
				end else if (stat.op == OP_DELETE) begin
					state_d = stat.at_edge ? S_REPLY : S_MOVE;
				end else begin
					state_d = S_READ;
				end
			end
			S_MOVE: begin
				if (stat.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = (stat.op == OP_INSERT) ? S_PUT : S_REPLY;
			end
			S_PUT: begin
				state_d = S_REPLY;
			end
			S_READ: begin
				state_d = S_REPLY;
			end
			S_REPLY: begin
				if (stat.slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			S_CHECK: begin
				cmd.init_ptr = 1'b1;
			end
			S_MOVE: begin
				cmd.step = 1'b1;
			end
			S_PUT: begin
				cmd.put = 1'b1;
			end
			S_READ: begin
				cmd.read_pos = 1'b1;
			end
			S_REPLY: begin
				cmd.commit = stat.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hdl/ial_dp.sv
// Datapath with the entry memory, the count, the shift pointer and the result register.
module ial_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ial_pkg::cmd_t       cmd,
	output ial_pkg::stat_t      stat,
	input  logic [1:0]          operation,
	input  logic [7:0]          position,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  read_value,
	output logic [7:0]          count
);
	import ial_pkg::*;

	logic [31:0]       mem [CAPACITY];
	op_t               op_q;
	logic [7:0]        pos_q;
	logic [31:0]       val_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] dst_s1;
	logic              mv_s1;
	logic [31:0]       rd_data_s1;
	logic              out_valid_q;
	status_t           status_q;
	logic [31:0]       read_value_q;
	logic [7:0]        count_out_q;

	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [ADDR_W-1:0] pos_addr;
	logic [ADDR_W-1:0] rd_addr;
	status_t           code;
	logic [CNT_W-1:0]  count_next;
	logic [CMP_W-1:0]  count_next_ext;

	assign pos_ext  = CMP_W'(pos_q);
	assign cnt_ext  = CMP_W'(count_q);
	assign pos_addr = pos_ext[ADDR_W-1:0];
	assign rd_addr  = cmd.read_pos ? pos_addr : ptr_q;

	always_comb begin
		code = ST_DONE;
		case (op_q)
			OP_INSERT: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					code = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					code = ST_BAD_POS;
				end
			end
			OP_DELETE, OP_READ: begin
				if (count_q == '0) begin
					code = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					code = ST_BAD_POS;
				end
			end
			default: begin
				code = ST_DONE;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (code == ST_DONE && op_q == OP_INSERT) begin
			count_next = count_q + CNT_W'(1);
		end else if (code == ST_DONE && op_q == OP_DELETE) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_next_ext = CMP_W'(count_next);

	always_comb begin
		stat.ok        = (code == ST_DONE);
		stat.op        = op_q;
		stat.at_edge   = (op_q == OP_INSERT) ? (pos_ext == cnt_ext)
		                                     : ((pos_ext + CMP_W'(1)) == cnt_ext);
		stat.last      = (op_q == OP_INSERT) ? (ptr_q == pos_addr)
		                                     : ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
		stat.slot_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.init_ptr) begin
			if (op_q == OP_INSERT) begin
				ptr_q <= ADDR_W'(count_q - CNT_W'(1));
			end else begin
				ptr_q <= pos_addr + ADDR_W'(1);
			end
		end else if (cmd.step) begin
			if (op_q == OP_INSERT) begin
				ptr_q  <= ptr_q - ADDR_W'(1);
				dst_s1 <= ptr_q + ADDR_W'(1);
			end else begin
				ptr_q  <= ptr_q + ADDR_W'(1);
				dst_s1 <= ptr_q - ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			mem[dst_s1] <= rd_data_s1;
		end else if (cmd.put) begin
			mem[pos_addr] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step || cmd.read_pos) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= code;
			read_value_q <= (op_q == OP_READ && code == ST_DONE) ? rd_data_s1 : '0;
			count_out_q  <= count_next_ext[7:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_out_q;

endmodule

FILE: hdl/indexed_array_list.sv
// Top level of the indexed array list: controller, datapath and checks.
//
// Usage: a word on the input channel carries operation, position and value
// and is taken at a clock edge with in_valid high and in_stall low. Each
// accepted word gives exactly one result word on the output channel with
// status, read_value and count, taken when out_valid is high and out_stall
// is low. The list sits in a single memory with one read and one write port.
// A request is checked first; a refused one goes straight to the reply. A read
// reads the entry at the position, an insert at the end writes the value, a
// delete of the last entry only updates the count. Otherwise a shift moves
// one entry per cycle through the memory ports over the entries above the
// position, and an insert then writes the value. One word is in work at a
// time; in_stall drops the cycle after the result is loaded.
// The result register holds a finished word while the receiver stalls and the
// block can take the next request meanwhile; a new result waits for the slot.
// Reset clears the count, out_valid and the move flag; the memory is not cleared.
`include "indexed_array_list_macros.svh"

module indexed_array_list (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [7:0]         count
);
	import ial_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ial_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ial_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	`IAL_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "ready after accept")
	`IAL_ASSERT_SAME(a_zero_unless_done, out_valid && status != ST_DONE, read_value == '0, "read_value set on refusal")
	`IAL_ASSERT_SAME(a_full_count, out_valid && status == ST_FULL, count == 8'(CAPACITY), "full without full count")
	`IAL_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid, "result not presented")

endmodule
